### rtl/tmrq_pkg.sv
package tmrq_pkg;

    localparam int ID_W   = 4;
    localparam int TIME_W = 63;
    localparam int IVL_W  = 32;
    localparam int KIND_W = 3;
    localparam int CMD_W  = 2;
    localparam int ID_SPACE = 1 << ID_W;

    typedef logic [CMD_W-1:0]  cmd_t;
    typedef logic [KIND_W-1:0] kind_t;
    typedef logic [TIME_W-1:0] time_t;

    localparam cmd_t CMD_ADD    = 2'd0;
    localparam cmd_t CMD_CANCEL = 2'd1;
    localparam cmd_t CMD_TICK   = 2'd2;

    localparam kind_t KIND_ADD_OK   = 3'd0;
    localparam kind_t KIND_ADD_REJ  = 3'd1;
    localparam kind_t KIND_CANCEL   = 3'd2;
    localparam kind_t KIND_EXPIRED  = 3'd3;
    localparam kind_t KIND_NONE     = 3'd4;

    localparam time_t TIME_MAX = {TIME_W{1'b1}};

endpackage

### rtl/tmrq_ram.sv
module tmrq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

### rtl/timer_expiry_queue.sv
// Add and cancel take one scan of the N = min(TIMER_SLOTS, 16) slots of the slot table,
// and the result beat is valid once that scan has ended.
// A tick runs (E + 1) selection scans for E expired timers, one rearm pass and one final
// scan, each over all N slots, and its first beat is valid once the final scan has ended;
// the run then moves one beat per cycle while m_tready is high.
// Throughput: one command at a time; s_tready returns the cycle after the last beat.
// Reset (aresetn low, synchronous) disarms every slot and returns to idle.
module timer_expiry_queue #(
    parameter int TIMER_SLOTS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // s_tdata, low to high: timer_id[3:0], expire_time[66:4],
    // repeat_interval[98:67], current_time[161:99], zero fill to 168 bits.
    input  logic [167:0] s_tdata,
    // s_tuser: command[1:0].
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // m_tdata, low to high: expired_id[3:0], found[4], earliest_changed[5],
    // next_expire[68:6], next_valid[69], zero fill to 72 bits.
    output logic [71:0] m_tdata,
    // m_tuser: kind[2:0].
    output logic [2:0]  m_tuser,
    output logic        m_tlast
);
    import tmrq_pkg::*;

    // Only ids that fit the four-bit id field can ever be armed.
    localparam int NSLOT = (TIMER_SLOTS < ID_SPACE) ? TIMER_SLOTS : ID_SPACE;
    localparam int IDXW  = $clog2(NSLOT);
    localparam int CNTW  = $clog2(NSLOT + 1);
    localparam logic [IDXW-1:0] LAST_IDX = IDXW'(NSLOT - 1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_REARM = 2'd2;
    localparam logic [1:0] S_OUT   = 2'd3;

    logic [1:0]        state_reg;
    logic [NSLOT-1:0]  armed_reg;
    logic [NSLOT-1:0]  taken_reg;
    logic [IDXW-1:0]   list_reg [NSLOT];
    logic [CNTW-1:0]   n_reg;
    logic [CNTW-1:0]   out_cnt_reg;

    cmd_t              cmd_reg;
    logic [ID_W-1:0]   id_reg;
    time_t             when_reg;
    logic [IVL_W-1:0]  ivl_reg;
    time_t             now_reg;

    // Scan sequencer: one slot address issued per cycle, its data read back in the next cycle.
    logic              issue_reg;
    logic [IDXW-1:0]   scan_idx_reg;
    logic              rd_vld_reg;
    logic [IDXW-1:0]   rd_idx_reg;
    logic              sel_reg;      // selection scan of a tick (expired only)

    logic              best_v_reg;
    time_t             best_exp_reg;
    logic [IDXW-1:0]   best_id_reg;

    kind_t             res_kind_reg;
    logic [ID_W-1:0]   res_id_reg;
    logic              res_found_reg;
    logic              res_chg_reg;
    time_t             nx_exp_reg;
    logic              nx_vld_reg;

    time_t             exp_rd;
    logic [IVL_W-1:0]  ivl_rd;

    logic              in_acc;
    logic              out_acc;
    logic              id_in_range;
    logic [IDXW-1:0]   id_idx;
    logic              scan_last;
    logic              eligible;
    logic              cur_v;
    time_t             cur_exp;
    logic [IDXW-1:0]   cur_id;
    logic              add_ok;
    logic              add_chg;
    logic [TIME_W:0]   rearm_sum;
    time_t             rearm_exp;
    logic              rearm_hit;
    logic              exp_we;
    logic [IDXW-1:0]   exp_waddr;
    time_t             exp_wdata;
    logic              ivl_we;
    logic              out_last;

    assign s_tready = (state_reg == S_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign out_acc  = m_tvalid && m_tready;

    assign id_in_range = {1'b0, id_reg} < (ID_W + 1)'(NSLOT);
    assign id_idx      = id_reg[IDXW-1:0];
    assign scan_last   = rd_vld_reg && (rd_idx_reg == LAST_IDX);

    // The one shared compare: is the slot being read a better minimum so far.
    assign eligible = armed_reg[rd_idx_reg] &&
                      (!sel_reg || (!taken_reg[rd_idx_reg] && (exp_rd <= now_reg)));
    always_comb begin
        cur_v   = best_v_reg;
        cur_exp = best_exp_reg;
        cur_id  = best_id_reg;
        if (rd_vld_reg && eligible && (!best_v_reg || (exp_rd < best_exp_reg))) begin
            cur_v   = 1'b1;
            cur_exp = exp_rd;
            cur_id  = rd_idx_reg;
        end
    end

    assign add_ok  = id_in_range && !armed_reg[id_idx];
    assign add_chg = !cur_v || (when_reg < cur_exp);

    // Rearm adder, saturating at the largest 63-bit time.
    assign rearm_sum = {1'b0, now_reg} + {(TIME_W + 1 - IVL_W)'(0), ivl_rd};
    assign rearm_exp = rearm_sum[TIME_W] ? TIME_MAX : rearm_sum[TIME_W-1:0];
    assign rearm_hit = (state_reg == S_REARM) && rd_vld_reg && taken_reg[rd_idx_reg];

    wire add_end = (state_reg == S_SCAN) && scan_last && !sel_reg && (cmd_reg == CMD_ADD);

    assign exp_we    = (add_end && add_ok) || (rearm_hit && (ivl_rd != '0));
    assign exp_waddr = (state_reg == S_REARM) ? rd_idx_reg : id_idx;
    assign exp_wdata = (state_reg == S_REARM) ? rearm_exp : when_reg;
    assign ivl_we    = add_end && add_ok;

    tmrq_ram #(.WIDTH(TIME_W), .DEPTH(NSLOT)) u_exp_ram (
        .aclk  (aclk),
        .we    (exp_we),
        .waddr (exp_waddr),
        .wdata (exp_wdata),
        .raddr (scan_idx_reg),
        .rdata (exp_rd)
    );

    tmrq_ram #(.WIDTH(IVL_W), .DEPTH(NSLOT)) u_ivl_ram (
        .aclk  (aclk),
        .we    (ivl_we),
        .waddr (id_idx),
        .wdata (ivl_reg),
        .raddr (scan_idx_reg),
        .rdata (ivl_rd)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            armed_reg   <= '0;
            taken_reg   <= '0;
            n_reg       <= '0;
            out_cnt_reg <= '0;
            issue_reg   <= 1'b0;
            rd_vld_reg  <= 1'b0;
            sel_reg     <= 1'b0;
            best_v_reg  <= 1'b0;
        end else begin
            rd_vld_reg <= issue_reg;
            rd_idx_reg <= scan_idx_reg;
            if (issue_reg) begin
                if (scan_idx_reg == LAST_IDX) begin
                    issue_reg <= 1'b0;
                end else begin
                    scan_idx_reg <= scan_idx_reg + 1'b1;
                end
            end

            case (state_reg)
                S_IDLE: begin
                    if (in_acc) begin
                        cmd_reg  <= s_tuser;
                        id_reg   <= s_tdata[3:0];
                        when_reg <= s_tdata[66:4];
                        ivl_reg  <= s_tdata[98:67];
                        now_reg  <= s_tdata[161:99];
                        // Only a cancel reports found; every other result carries zero.
                        res_found_reg <= 1'b0;
                        if (s_tuser == CMD_ADD || s_tuser == CMD_CANCEL ||
                            s_tuser == CMD_TICK) begin
                            state_reg    <= S_SCAN;
                            issue_reg    <= 1'b1;
                            scan_idx_reg <= '0;
                            best_v_reg   <= 1'b0;
                            sel_reg      <= (s_tuser == CMD_TICK);
                            taken_reg    <= '0;
                            n_reg        <= '0;
                            out_cnt_reg  <= '0;
                        end
                        if (s_tuser == CMD_CANCEL) begin
                            if ({1'b0, s_tdata[3:0]} < (ID_W + 1)'(NSLOT)) begin
                                res_found_reg <= armed_reg[s_tdata[IDXW-1:0]];
                                armed_reg[s_tdata[IDXW-1:0]] <= 1'b0;
                            end
                        end
                    end
                end
                S_SCAN: begin
                    best_v_reg   <= cur_v;
                    best_exp_reg <= cur_exp;
                    best_id_reg  <= cur_id;
                    if (scan_last) begin
                        if (sel_reg) begin
                            if (cur_v) begin
                                // Next expired timer in (expiry, id) order.
                                taken_reg[cur_id] <= 1'b1;
                                list_reg[n_reg[IDXW-1:0]] <= cur_id;
                                n_reg        <= n_reg + 1'b1;
                                issue_reg    <= 1'b1;
                                scan_idx_reg <= '0;
                                best_v_reg   <= 1'b0;
                            end else begin
                                state_reg    <= S_REARM;
                                issue_reg    <= 1'b1;
                                scan_idx_reg <= '0;
                            end
                        end else begin
                            state_reg     <= S_OUT;
                            res_id_reg    <= id_reg;
                            res_chg_reg   <= 1'b0;
                            nx_vld_reg    <= cur_v;
                            nx_exp_reg    <= cur_v ? cur_exp : '0;
                            case (cmd_reg)
                                CMD_ADD: begin
                                    if (add_ok) begin
                                        res_kind_reg <= KIND_ADD_OK;
                                        res_chg_reg  <= add_chg;
                                        armed_reg[id_idx] <= 1'b1;
                                        nx_vld_reg   <= 1'b1;
                                        nx_exp_reg   <= add_chg ? when_reg : cur_exp;
                                    end else begin
                                        res_kind_reg <= KIND_ADD_REJ;
                                    end
                                end
                                CMD_CANCEL: begin
                                    res_kind_reg <= KIND_CANCEL;
                                end
                                default: begin
                                    res_id_reg   <= '0;
                                    res_kind_reg <= (n_reg != '0) ? KIND_EXPIRED : KIND_NONE;
                                end
                            endcase
                        end
                    end
                end
                S_REARM: begin
                    // One-shot timers are freed; repeating ones were rewritten.
                    if (rearm_hit && (ivl_rd == '0)) begin
                        armed_reg[rd_idx_reg] <= 1'b0;
                    end
                    if (scan_last) begin
                        state_reg    <= S_SCAN;
                        sel_reg      <= 1'b0;
                        issue_reg    <= 1'b1;
                        scan_idx_reg <= '0;
                        best_v_reg   <= 1'b0;
                    end
                end
                S_OUT: begin
                    if (out_acc) begin
                        if (out_last) begin
                            state_reg <= S_IDLE;
                        end else begin
                            out_cnt_reg <= out_cnt_reg + 1'b1;
                        end
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // An expired-timer run walks the list; every other result is a single beat.
    assign out_last = (res_kind_reg != KIND_EXPIRED) || (out_cnt_reg == n_reg - 1'b1);

    assign m_tvalid = (state_reg == S_OUT);
    assign m_tuser  = res_kind_reg;
    assign m_tlast  = out_last;
    assign m_tdata  = {2'b00, nx_vld_reg, nx_exp_reg, res_chg_reg, res_found_reg,
                       (res_kind_reg == KIND_EXPIRED) ?
                           ID_W'(list_reg[out_cnt_reg[IDXW-1:0]]) : res_id_reg};

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid)) else $error("input and output active together");
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        n_reg <= CNTW'(NSLOT)) else $error("expired count exceeds slot count");
    a_out_index: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && res_kind_reg == KIND_EXPIRED) |-> (out_cnt_reg < n_reg))
        else $error("expired run index past end of list");
    a_taken_armed: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SCAN && sel_reg) |-> ((taken_reg & ~armed_reg) == '0))
        else $error("selected timer is not armed");
endmodule
